[src/mphm_pkg.sv]
// ----------------------------------------------------------------------------
// mphm_pkg
// Shared types, constants and scaling tables of the multichannel meter.
// ----------------------------------------------------------------------------
`default_nettype none

package mphm_pkg;

  // channel count and level resolution
  localparam int CHANNEL_COUNT       = 6;
  localparam int LEVEL_FRACTION_BITS = 12;
  localparam int SCALED_CHANNELS     = 6;

  localparam int CH_AW    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int LEVEL_W  = LEVEL_FRACTION_BITS + 1;
  localparam int STEP_W   = 13;
  localparam int OUT_LW   = 13;
  localparam int CMP_W    = (LEVEL_W > STEP_W) ? LEVEL_W : STEP_W;
  localparam int DEN_W    = 15;
  localparam int NUM_W    = 17;
  localparam int DIV_CW   = $clog2(LEVEL_FRACTION_BITS + 1);

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(1) << LEVEL_FRACTION_BITS;

  // spans of the channels, in raw units
  localparam logic [DEN_W-1:0] PWR_DEN_STD = DEN_W'(1100);
  localparam logic [DEN_W-1:0] PWR_DEN_QRP = DEN_W'(100);
  localparam logic [DEN_W-1:0] PWR_DEN_AMP = DEN_W'(19000);
  localparam logic [DEN_W-1:0] ALC_DEN     = DEN_W'(10);
  localparam logic [DEN_W-1:0] COMP_DEN    = DEN_W'(25);
  localparam logic [DEN_W-1:0] SWR_DEN     = DEN_W'(200);
  localparam logic [DEN_W-1:0] CUR_DEN     = DEN_W'(2500);
  localparam logic [DEN_W-1:0] SMTR_DEN    = DEN_W'(1500);
  localparam logic signed [NUM_W-1:0] SWR_OFFSET = NUM_W'(100);

  typedef enum logic [2:0] {
    CH_POWER   = 3'd0,
    CH_ALC     = 3'd1,
    CH_COMP    = 3'd2,
    CH_SWR     = 3'd3,
    CH_CURRENT = 3'd4,
    CH_SMETER  = 3'd5
  } chan_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_QRP_MODE        = 2'd0,
    REG_AMP_MODE        = 2'd1,
    REG_DECAY_STEP      = 2'd2,
    REG_PEAK_DECAY_STEP = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SAMPLE,
    ST_TICK
  } st_e;

  typedef struct packed {
    logic              qrp_mode;
    logic              amplifier_mode;
    logic [STEP_W-1:0] decay_step;
    logic [STEP_W-1:0] peak_decay_step;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] target;
    logic [LEVEL_W-1:0] display;
    logic [LEVEL_W-1:0] peak;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               we;
    logic [CH_AW-1:0]   waddr;
    entry_t             wdata;
    logic               re;
    logic [CH_AW-1:0]   raddr;
  } ram_req_t;

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                           done;
    logic [LEVEL_FRACTION_BITS-1:0] quo;
  } div_rsp_t;

  // span of a channel, power follows the mode bits
  function automatic logic [DEN_W-1:0] span_den(input logic [2:0] ch, input logic qrp,
                                                input logic amp);
    logic [DEN_W-1:0] d;
    case (ch)
      CH_POWER:   d = amp ? PWR_DEN_AMP : (qrp ? PWR_DEN_QRP : PWR_DEN_STD);
      CH_ALC:     d = ALC_DEN;
      CH_COMP:    d = COMP_DEN;
      CH_SWR:     d = SWR_DEN;
      CH_CURRENT: d = CUR_DEN;
      CH_SMETER:  d = SMTR_DEN;
      default:    d = PWR_DEN_STD;
    endcase
    return d;
  endfunction

  // zero point of a channel
  function automatic logic signed [NUM_W-1:0] span_off(input logic [2:0] ch);
    logic signed [NUM_W-1:0] o;
    case (ch)
      CH_SWR:  o = SWR_OFFSET;
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

[src/mphm_if.sv]
// ----------------------------------------------------------------------------
// mphm_if
// Valid/ready channels of the meter: sample/tick input and level output.
// ----------------------------------------------------------------------------
`default_nettype none

interface mphm_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [2:0]         channel;
  logic signed [15:0] raw_value;

  modport source (output valid, output operation, output channel, output raw_value,
                  input ready);
  modport sink (input valid, input operation, input channel, input raw_value,
                output ready);
endinterface

interface mphm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  channel_id;
  logic [12:0] display_level;
  logic [12:0] peak_level;
  logic        changed;
  logic        last;

  modport source (output valid, output channel_id, output display_level,
                  output peak_level, output changed, output last, input ready);
  modport sink (input valid, input channel_id, input display_level,
                input peak_level, input changed, input last, output ready);
endinterface

`default_nettype wire

[src/mphm_ram.sv]
// ----------------------------------------------------------------------------
// mphm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mphm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/mphm_div.sv]
// ----------------------------------------------------------------------------
// mphm_div
// Restoring fraction divider: floor(num * 2^LEVEL_FRACTION_BITS / den) for
// num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mphm_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mphm_pkg::div_req_t req_i,
  output      mphm_pkg::div_rsp_t rsp_o
);
  import mphm_pkg::*;

  logic [DEN_W-1:0]               rem_q, rem_d;
  logic [DEN_W-1:0]               den_q, den_d;
  logic [LEVEL_FRACTION_BITS-1:0] quo_q, quo_d;
  logic [DIV_CW-1:0]              cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [DEN_W:0]                 shifted;
  logic                           fits;

  // one compare-subtract step per cycle
  always_comb begin
    shifted = {rem_q, 1'b0};
    fits    = shifted >= {1'b0, den_q};
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = DIV_CW'(LEVEL_FRACTION_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(shifted - {1'b0, den_q}) : DEN_W'(shifted);
      quo_d = {quo_q[LEVEL_FRACTION_BITS-2:0], fits};
      cnt_d = cnt_q - DIV_CW'(1);
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

[src/mphm_ctrl.sv]
// ----------------------------------------------------------------------------
// mphm_ctrl
// Sequencer of the meter: scales samples, walks the channel RAM on ticks
// with read-modify-write, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mphm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mphm_pkg::cfg_t       cfg_i,
  mphm_in_if.sink                   in_s,
  mphm_out_if.source                out_s,
  output      mphm_pkg::ram_req_t   ram_req_o,
  input  wire mphm_pkg::entry_t     ram_rdata_i,
  output      mphm_pkg::div_req_t   div_req_o,
  input  wire mphm_pkg::div_rsp_t   div_rsp_i
);
  import mphm_pkg::*;

  st_e                      state_q, state_d;
  logic [CH_AW-1:0]         idx_q, idx_d;
  logic [LEVEL_W-1:0]       lvl_q, lvl_d;
  logic [CHANNEL_COUNT-1:0] vld_q, vld_d;

  logic              out_vld_q, out_vld_d;
  logic [2:0]        out_ch_q, out_ch_d;
  logic [OUT_LW-1:0] out_disp_q, out_disp_d;
  logic [OUT_LW-1:0] out_peak_q, out_peak_d;
  logic              out_chg_q, out_chg_d;
  logic              out_last_q, out_last_d;

  logic                    in_fire;
  logic                    out_free;
  logic                    ch_ok;
  logic                    idx_last;
  logic [DEN_W-1:0]        den;
  logic signed [NUM_W-1:0] num_s;
  logic signed [NUM_W-1:0] den_s;
  logic                    sat_low;
  logic                    sat_high;
  entry_t                  cur;
  entry_t                  nxt;
  logic [CMP_W-1:0]        gap;
  logic [LEVEL_W-1:0]      new_disp;
  logic [LEVEL_W-1:0]      new_peak;
  logic                    emit;
  logic                    chg;

  assign in_fire  = in_s.valid && in_s.ready;
  assign out_free = !out_vld_q || out_s.ready;
  assign idx_last = idx_q == CH_AW'(CHANNEL_COUNT - 1);
  assign ch_ok    = (32'(in_s.channel) < CHANNEL_COUNT) &&
                    (32'(in_s.channel) < SCALED_CHANNELS);

  // sample scaling: offset, span and saturation
  always_comb begin
    den      = span_den(in_s.channel, cfg_i.qrp_mode, cfg_i.amplifier_mode);
    num_s    = NUM_W'(in_s.raw_value) - span_off(in_s.channel);
    den_s    = signed'({{(NUM_W-DEN_W){1'b0}}, den});
    sat_low  = num_s <= 0;
    sat_high = num_s >= den_s;
  end

  // entry as read, never-written channels read as zero
  assign cur = vld_q[idx_q] ? ram_rdata_i : '0;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_s.operation == OP_TICK) begin
            state_d = ST_TICK;
          end else if (ch_ok) begin
            state_d = (sat_low || sat_high) ? ST_SAMPLE : ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        if (div_rsp_i.done) begin
          state_d = ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (out_free && idx_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_d      = idx_q;
    lvl_d      = lvl_q;
    vld_d      = vld_q;
    ram_req_o  = '0;
    div_req_o  = '0;
    emit       = 1'b0;
    chg        = 1'b0;
    nxt        = cur;
    gap        = '0;
    new_disp   = cur.display;
    new_peak   = cur.peak;
    in_s.ready = state_q == ST_IDLE;

    div_req_o.num = DEN_W'(num_s);
    div_req_o.den = den;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_s.operation == OP_TICK) begin
            idx_d           = '0;
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = '0;
          end else if (ch_ok) begin
            idx_d           = CH_AW'(in_s.channel);
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = CH_AW'(in_s.channel);
            lvl_d           = sat_high ? FULL_LEVEL : '0;
            div_req_o.start = !(sat_low || sat_high);
          end
        end
      end
      ST_SCALE: begin
        if (div_rsp_i.done) begin
          lvl_d = {1'b0, div_rsp_i.quo};
        end
      end
      ST_SAMPLE: begin
        // display and peak jump up to the new target
        nxt.target  = lvl_q;
        nxt.display = (lvl_q > cur.display) ? lvl_q : cur.display;
        nxt.peak    = (lvl_q > cur.peak) ? lvl_q : cur.peak;
        emit        = out_free;
      end
      ST_TICK: begin
        // display falls toward target, then peak toward the new display
        if (cur.display > cur.target) begin
          gap      = CMP_W'(cur.display - cur.target);
          new_disp = (CMP_W'(cfg_i.decay_step) >= gap) ? cur.target :
                     LEVEL_W'(CMP_W'(cur.display) - CMP_W'(cfg_i.decay_step));
          chg      = 1'b1;
        end
        if (cur.peak > new_disp) begin
          gap      = CMP_W'(cur.peak - new_disp);
          new_peak = (CMP_W'(cfg_i.peak_decay_step) >= gap) ? new_disp :
                     LEVEL_W'(CMP_W'(cur.peak) - CMP_W'(cfg_i.peak_decay_step));
          chg      = 1'b1;
        end
        nxt.display = new_disp;
        nxt.peak    = new_peak;
        emit        = out_free;
        if (out_free && !idx_last) begin
          idx_d           = idx_q + CH_AW'(1);
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_q + CH_AW'(1);
        end
      end
      default: ;
    endcase

    ram_req_o.we    = emit;
    ram_req_o.waddr = idx_q;
    ram_req_o.wdata = nxt;
    if (emit) begin
      vld_d[idx_q] = 1'b1;
    end
  end

  // output register
  always_comb begin
    out_vld_d  = emit || (out_vld_q && !out_s.ready);
    out_ch_d   = out_ch_q;
    out_disp_d = out_disp_q;
    out_peak_d = out_peak_q;
    out_chg_d  = out_chg_q;
    out_last_d = out_last_q;
    if (emit) begin
      out_ch_d   = 3'(idx_q);
      out_disp_d = OUT_LW'(nxt.display);
      out_peak_d = OUT_LW'(nxt.peak);
      out_chg_d  = chg;
      out_last_d = (state_q == ST_SAMPLE) || idx_last;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lvl_q      <= lvl_d;
    out_ch_q   <= out_ch_d;
    out_disp_q <= out_disp_d;
    out_peak_q <= out_peak_d;
    out_chg_q  <= out_chg_d;
    out_last_q <= out_last_d;
  end

  assign out_s.valid         = out_vld_q;
  assign out_s.channel_id    = out_ch_q;
  assign out_s.display_level = out_disp_q;
  assign out_s.peak_level    = out_peak_q;
  assign out_s.changed       = out_chg_q;
  assign out_s.last          = out_last_q;

endmodule

`default_nettype wire

[src/multichannel_peak_hold_meter_unit.sv]
// ----------------------------------------------------------------------------
// multichannel_peak_hold_meter_unit
// Six-channel bar meter with fall-off ballistics and peak hold; channel
// state lives in one RAM entry per channel.
//
//   channel   dir   beat contents
//   in_i      in    operation, channel, raw_value
//   out_o     out   channel_id, display_level, peak_level, changed, last
//   cfg       in    cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// A tick does one RAM read-modify-write per channel, in channel order. A
// sample whose reading saturates skips the bit-serial divider; any other
// sample waits for the divider to finish.
// Reset clears all channels through per-entry valid bits, no sweep needed.
// A busy output register stalls the writeback; the next item is taken once
// the current one has handed all its beats to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_peak_hold_meter_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mphm_in_if.sink                            in_i,
  mphm_out_if.source                         out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_idx_i,
  input  wire logic [mphm_pkg::STEP_W-1:0]   cfg_wdata_i
);
  import mphm_pkg::*;

  cfg_t     cfg_q, cfg_d;
  ram_req_t ram_req;
  entry_t   ram_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_QRP_MODE:        cfg_d.qrp_mode        = cfg_wdata_i[0];
        REG_AMP_MODE:        cfg_d.amplifier_mode  = cfg_wdata_i[0];
        REG_DECAY_STEP:      cfg_d.decay_step      = cfg_wdata_i;
        REG_PEAK_DECAY_STEP: cfg_d.peak_decay_step = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.qrp_mode        <= 1'b0;
      cfg_q.amplifier_mode  <= 1'b0;
      cfg_q.decay_step      <= STEP_W'(205);
      cfg_q.peak_decay_step <= STEP_W'(41);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // channel state memory
  mphm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNEL_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // level divider
  mphm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  mphm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_s        (in_i),
    .out_s       (out_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

`ifndef SYNTHESIS
  // a tick never reads the entry it is writing back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("ram read and write collide on one entry");

  // every writeback puts a beat in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |=> out_o.valid)
    else $error("writeback without output beat");

  // the peak marker never sits below the bar
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.peak_level >= out_o.display_level))
    else $error("peak below display");

  // no new item while the divider is still busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !in_i.ready)
    else $error("input taken during division");
`endif

endmodule

`default_nettype wire

[test/multichannel_peak_hold_meter_unit_tb.sv]
// ----------------------------------------------------------------------------
// multichannel_peak_hold_meter_unit_tb
// Self-checking bench for the six-channel peak hold meter. A level model
// follows every accepted sample and tick, and queues the level beats the
// block should send. A monitor compares each output beat, field by field,
// with the oldest queued beat. Directed tests cover reset state, scaling
// extremes, the power modes and the decay step extremes. A random mix then
// runs under several register settings, with idle gaps on both channels in all but one.
// ----------------------------------------------------------------------------
module multichannel_peak_hold_meter_unit_tb;
  import mphm_pkg::*;

  localparam int CHANNELS      = mphm_pkg::CHANNEL_COUNT;
  localparam int FULL          = 1 << mphm_pkg::LEVEL_FRACTION_BITS;
  localparam int SWR_ZERO      = 100;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 55;
  localparam int IDLE_PCT      = 6;

  // channel codes with no scaling
  localparam logic [2:0] CH_SPARE_A = 3'd6;
  localparam logic [2:0] CH_SPARE_B = 3'd7;

  typedef struct {
    logic [2:0]  chan;
    logic [12:0] display;
    logic [12:0] peak;
    logic        changed;
    logic        last;
  } level_beat_t;

  logic clk_i;
  logic rst_ni;
  logic              cfg_we;
  logic [1:0]        cfg_idx;
  logic [STEP_W-1:0] cfg_wdata;

  mphm_in_if  in_bus ();
  mphm_out_if out_bus ();

  multichannel_peak_hold_meter_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // level model state and registers
  int   target_lvl  [CHANNELS];
  int   display_lvl [CHANNELS];
  int   peak_lvl    [CHANNELS];
  logic qrp_sel;
  logic amp_sel;
  int   display_drop;
  int   peak_drop;

  level_beat_t beats_due[$];

  int fail_count;
  int cycle_count;
  int idle_pct;
  int samples_sent;
  int ticks_sent;
  int ignored_sent;
  int beats_checked;
  int settings_used;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // full span of a channel in raw units
  function automatic int meter_span(input logic [2:0] ch);
    int span;
    case (ch)
      CH_POWER:   span = amp_sel ? 19000 : (qrp_sel ? 100 : 1100);
      CH_ALC:     span = 10;
      CH_COMP:    span = 25;
      CH_SWR:     span = 200;
      CH_CURRENT: span = 2500;
      default:    span = 1500;
    endcase
    return span;
  endfunction

  // raw reading to fill level, saturating at both ends
  function automatic int fill_level(input logic [2:0] ch, input logic signed [15:0] raw);
    int num;
    int span;
    num  = int'(raw);
    span = meter_span(ch);
    if (ch == CH_SWR) num = num - SWR_ZERO;
    if (num <= 0) return 0;
    if (num >= span) return FULL;
    return (num * FULL) / span;
  endfunction

  // update the model for one accepted beat and queue the level beats it causes
  task automatic predict_levels(input op_e op, input logic [2:0] ch,
                                input logic signed [15:0] raw);
    level_beat_t lb;
    int lvl;
    int next_lvl;
    logic moved;
    if (op == OP_SAMPLE) begin
      if (ch >= CHANNELS) return;
      lvl = fill_level(ch, raw);
      target_lvl[ch] = lvl;
      if (lvl > display_lvl[ch]) display_lvl[ch] = lvl;
      if (lvl > peak_lvl[ch]) peak_lvl[ch] = lvl;
      lb.chan    = ch;
      lb.display = display_lvl[ch][12:0];
      lb.peak    = peak_lvl[ch][12:0];
      lb.changed = 1'b0;
      lb.last    = 1'b1;
      beats_due.push_back(lb);
      return;
    end
    // tick: display falls toward target, then peak toward the new display
    for (int i = 0; i < CHANNELS; i++) begin
      moved = 1'b0;
      if (display_lvl[i] > target_lvl[i]) begin
        next_lvl = display_lvl[i] - display_drop;
        display_lvl[i] = (next_lvl < target_lvl[i]) ? target_lvl[i] : next_lvl;
        moved = 1'b1;
      end
      if (peak_lvl[i] > display_lvl[i]) begin
        next_lvl = peak_lvl[i] - peak_drop;
        peak_lvl[i] = (next_lvl < display_lvl[i]) ? display_lvl[i] : next_lvl;
        moved = 1'b1;
      end
      lb.chan    = 3'(i);
      lb.display = display_lvl[i][12:0];
      lb.peak    = peak_lvl[i][12:0];
      lb.changed = moved;
      lb.last    = (i == CHANNELS - 1);
      beats_due.push_back(lb);
    end
  endtask

  // send one input beat; starts and ends at a falling edge
  task automatic send_item(input op_e op, input logic [2:0] ch,
                           input logic signed [15:0] raw);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.channel   <= ch;
    in_bus.raw_value <= raw;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    predict_levels(op, ch, raw);
    if (op == OP_TICK) ticks_sent++;
    else if (ch >= CHANNELS) ignored_sent++;
    else samples_sent++;
    @(negedge clk_i);
  endtask

  // hold off input until every queued beat is out, then let the block go quiet
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (beats_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // one register write while the block is idle
  task automatic write_reg(input cfg_reg_e idx, input logic [STEP_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      REG_QRP_MODE:   qrp_sel = val[0];
      REG_AMP_MODE:   amp_sel = val[0];
      REG_DECAY_STEP: display_drop = int'(val);
      default:        peak_drop = int'(val);
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all_regs(input logic qrp, input logic amp,
                                input int drop, input int pdrop);
    write_reg(REG_QRP_MODE, STEP_W'(qrp));
    write_reg(REG_AMP_MODE, STEP_W'(amp));
    write_reg(REG_DECAY_STEP, STEP_W'(drop));
    write_reg(REG_PEAK_DECAY_STEP, STEP_W'(pdrop));
    settings_used++;
  endtask

  // all channels start at zero
  task automatic test_reset_state();
    send_item(OP_TICK, CH_POWER, 16'sd0);
    settle();
  endtask

  // both ends of power and SWR scaling, in-span elsewhere, plus unscaled channels
  task automatic test_scaling_extremes();
    send_item(OP_SAMPLE, CH_POWER, 16'sh7fff);
    send_item(OP_SAMPLE, CH_POWER, 16'sh8000);
    send_item(OP_SAMPLE, CH_POWER, 16'sd550);
    send_item(OP_SAMPLE, CH_ALC, 16'sd5);
    send_item(OP_SAMPLE, CH_COMP, 16'sd13);
    send_item(OP_SAMPLE, CH_SWR, 16'sd99);
    send_item(OP_SAMPLE, CH_SWR, 16'sd300);
    send_item(OP_SAMPLE, CH_SWR, 16'sd200);
    send_item(OP_SAMPLE, CH_CURRENT, 16'sd1234);
    send_item(OP_SAMPLE, CH_SMETER, 16'sd1499);
    send_item(OP_SAMPLE, CH_SPARE_A, 16'sd700);
    send_item(OP_SAMPLE, CH_SPARE_B, -16'sd1);
    send_item(OP_TICK, CH_SPARE_B, 16'sh5a5a);
    send_item(OP_TICK, CH_ALC, -16'sd1);
    settle();
  endtask

  // low power, amplifier and both mode bits on the power channel
  task automatic test_power_modes();
    write_all_regs(1'b1, 1'b0, 205, 41);
    send_item(OP_SAMPLE, CH_POWER, 16'sd50);
    settle();
    write_all_regs(1'b0, 1'b1, 205, 41);
    send_item(OP_SAMPLE, CH_POWER, 16'sd9500);
    settle();
    write_all_regs(1'b1, 1'b1, 205, 41);
    send_item(OP_SAMPLE, CH_POWER, 16'sd19001);
    settle();
  endtask

  // zero steps hold everything, full steps drop straight to target
  task automatic test_decay_extremes();
    write_all_regs(1'b0, 1'b0, 0, 0);
    send_item(OP_SAMPLE, CH_ALC, 16'sd0);
    send_item(OP_TICK, CH_POWER, 16'sd0);
    settle();
    write_all_regs(1'b0, 1'b0, FULL, FULL);
    send_item(OP_SAMPLE, CH_COMP, 16'sd25);
    send_item(OP_SAMPLE, CH_COMP, 16'sd3);
    send_item(OP_TICK, CH_POWER, 16'sd0);
    settle();
  endtask

  // one random beat: mostly in-range samples and ticks, some wide readings
  task automatic send_random_item(output logic counted);
    int pick;
    int span;
    int lo;
    logic [2:0] ch;
    logic signed [15:0] raw;
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 3) begin
      send_item(OP_SAMPLE, 3'($urandom_range(6, 7)), 16'($urandom));
      counted = 1'b0;
    end else if (pick < 33) begin
      send_item(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
    end else begin
      ch = 3'($urandom_range(0, CHANNELS - 1));
      if (pick < 85) begin
        span = meter_span(ch);
        lo   = ((ch == CH_SWR) ? SWR_ZERO : 0) - span / 8;
        raw  = 16'(lo + int'($urandom_range(0, span + span / 4)));
      end else begin
        raw = 16'($urandom);
      end
      send_item(OP_SAMPLE, ch, raw);
    end
  endtask

  // random mix over several register settings
  task automatic test_random_mix();
    int done_items;
    logic counted;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_all_regs(1'b0, 1'b0, 205, 41);
        1: write_all_regs(1'b1, 1'b0, 0, FULL);
        2: write_all_regs(1'b0, 1'b1, FULL, 0);
        3: write_all_regs(1'(($urandom)), 1'($urandom),
                          $urandom_range(1, 600), $urandom_range(1, 200));
        4: write_all_regs(1'b0, 1'b0, $urandom_range(0, FULL), $urandom_range(0, FULL));
        default: write_all_regs(1'b1, 1'b0, $urandom_range(1, 50), $urandom_range(1, 20));
      endcase
      // one phase runs with no idling on either side
      idle_pct   = (phase == 4) ? 0 : IDLE_PCT;
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        send_random_item(counted);
        if (counted) done_items++;
        // sender holds off until the output has drained
        if (phase == 2 && done_items == PHASE_ITEMS / 2 && counted) settle();
      end
      settle();
    end
    idle_pct = IDLE_PCT;
  endtask

  // random output stalls
  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // compare each output beat with the oldest queued beat
  always @(posedge clk_i) begin : check_levels
    level_beat_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (beats_due.size() == 0) begin
        $error("unexpected level beat: channel_id %0d", out_bus.channel_id);
        fail_count++;
      end else begin
        want = beats_due.pop_front();
        beats_checked++;
        if (out_bus.channel_id !== want.chan) begin
          $error("channel_id: expected %0d, got %0d", want.chan, out_bus.channel_id);
          fail_count++;
        end
        if (out_bus.display_level !== want.display) begin
          $error("display_level: expected %0d, got %0d", want.display,
                 out_bus.display_level);
          fail_count++;
        end
        if (out_bus.peak_level !== want.peak) begin
          $error("peak_level: expected %0d, got %0d", want.peak, out_bus.peak_level);
          fail_count++;
        end
        if (out_bus.changed !== want.changed) begin
          $error("changed: expected %0d, got %0d", want.changed, out_bus.changed);
          fail_count++;
        end
        if (out_bus.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_bus.last);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multichannel_peak_hold_meter_unit: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_SAMPLE;
    in_bus.channel   = CH_POWER;
    in_bus.raw_value = '0;
    out_bus.ready    = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_QRP_MODE;
    cfg_wdata        = '0;
    fail_count       = 0;
    cycle_count      = 0;
    idle_pct         = IDLE_PCT;
    samples_sent     = 0;
    ticks_sent       = 0;
    ignored_sent     = 0;
    beats_checked    = 0;
    settings_used    = 1;
    qrp_sel          = 1'b0;
    amp_sel          = 1'b0;
    display_drop     = 205;
    peak_drop        = 41;
    for (int i = 0; i < CHANNELS; i++) begin
      target_lvl[i]  = 0;
      display_lvl[i] = 0;
      peak_lvl[i]    = 0;
    end

    // reset, released at a falling edge
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_scaling_extremes();
    test_power_modes();
    test_decay_extremes();
    test_random_mix();
    settle();

    $display("run covered %0d samples, %0d ticks and %0d samples on unscaled channels",
             samples_sent, ticks_sent, ignored_sent);
    $display("%0d level beats compared across %0d register settings",
             beats_checked, settings_used);
    if (fail_count == 0) begin
      $display("multichannel_peak_hold_meter_unit: match");
    end else begin
      $display("multichannel_peak_hold_meter_unit: mismatch");
    end
    $finish;
  end

endmodule
